[rtl/rud_pkg.sv]
// Shared types for the pipelined restoring unsigned divider.
// Holds the operand and result word structs and the per-stage control struct.
// No dependencies.
package rud_pkg;

    localparam int FIELD_W = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend_in;
        logic [FIELD_W-1:0] divisor_in;
    } operands_t;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient_out;
        logic [FIELD_W-1:0] remainder_out;
        logic               div_by_zero;
    } result_t;

    // Control that rides alongside the data through every stage.
    typedef struct packed {
        logic valid;
        logic dz;
    } ctl_t;

endpackage

[rtl/rud_step.sv]
// One restoring-division step with its pipeline register.
// Shifts the remainder/quotient pair, trial-subtracts the divisor, keeps or restores.
// Depends on rud_pkg.
module rud_step #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rud_pkg::ctl_t    ctl,
    input  logic [WIDTH-1:0] rem,
    input  logic [WIDTH-1:0] quo,
    input  logic [WIDTH-1:0] dvs,
    output rud_pkg::ctl_t    step_ctl,
    output logic [WIDTH-1:0] step_rem,
    output logic [WIDTH-1:0] step_quo,
    output logic [WIDTH-1:0] step_dvs
);
    import rud_pkg::*;

    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic             take;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    ctl_t             ctl_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;

    // The shifted remainder is one bit wider than the operands, so a divisor
    // with its top bit set still compares correctly.
    assign shifted  = {rem, quo[WIDTH-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dvs};
    assign take     = ~diff[WIDTH+1];
    assign rem_next = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    assign quo_next = {quo[WIDTH-2:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs;
    end

    assign step_ctl = ctl_reg;
    assign step_rem = rem_reg;
    assign step_quo = quo_reg;
    assign step_dvs = dvs_reg;

endmodule

[rtl/restoring_unsigned_divider_unit.sv]
// Pipelined restoring unsigned divider: one quotient bit per register stage.
// A word accepted at a clock edge passes the entry register, the step registers and
// the output register, and is then shown on result with done high.
// Throughput: one word per cycle; busy stays low, as the pipeline never stalls.
// Reset clears the valid bits of every stage and the done strobe; data is not reset.
// Depends on rud_pkg and rud_step.
module restoring_unsigned_divider_unit #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rud_pkg::operands_t operands,
    output logic               done,
    output rud_pkg::result_t   result
);
    import rud_pkg::*;

    logic [WIDTH-1:0] dividend_w;
    logic [WIDTH-1:0] divisor_w;

    ctl_t             ctl_s [0:WIDTH];
    logic [WIDTH-1:0] rem_s [0:WIDTH];
    logic [WIDTH-1:0] quo_s [0:WIDTH];
    logic [WIDTH-1:0] dvs_s [0:WIDTH];

    ctl_t             ctl0_reg;
    logic [WIDTH-1:0] quo0_reg;
    logic [WIDTH-1:0] dvs0_reg;

    logic [FIELD_W-1:0] quo_cut;
    logic [FIELD_W-1:0] rem_cut;

    logic    done_reg;
    result_t result_reg;
    result_t result_next;

    // Operands are taken at WIDTH bits: extended or cut as needed.
    if (WIDTH > FIELD_W)
    begin : g_ext
        assign dividend_w = {{(WIDTH-FIELD_W){1'b0}}, operands.dividend_in};
        assign divisor_w  = {{(WIDTH-FIELD_W){1'b0}}, operands.divisor_in};
        assign quo_cut    = quo_s[WIDTH][FIELD_W-1:0];
        assign rem_cut    = rem_s[WIDTH][FIELD_W-1:0];
    end
    else if (WIDTH == FIELD_W)
    begin : g_same
        assign dividend_w = operands.dividend_in;
        assign divisor_w  = operands.divisor_in;
        assign quo_cut    = quo_s[WIDTH];
        assign rem_cut    = rem_s[WIDTH];
    end
    else
    begin : g_cut
        assign dividend_w = operands.dividend_in[WIDTH-1:0];
        assign divisor_w  = operands.divisor_in[WIDTH-1:0];
        assign quo_cut    = {{(FIELD_W-WIDTH){1'b0}}, quo_s[WIDTH]};
        assign rem_cut    = {{(FIELD_W-WIDTH){1'b0}}, rem_s[WIDTH]};
    end

    assign busy = 1'b0;

    // Entry stage: capture the operands and flag a zero divisor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else
        begin
            ctl0_reg.valid <= start & ~busy;
            ctl0_reg.dz    <= (divisor_w == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        quo0_reg <= dividend_w;
        dvs0_reg <= divisor_w;
    end

    assign ctl_s[0] = ctl0_reg;
    assign rem_s[0] = '0;
    assign quo_s[0] = quo0_reg;
    assign dvs_s[0] = dvs0_reg;

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_step
        rud_step #(
            .WIDTH (WIDTH)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl_s[i]),
            .rem      (rem_s[i]),
            .quo      (quo_s[i]),
            .dvs      (dvs_s[i]),
            .step_ctl (ctl_s[i+1]),
            .step_rem (rem_s[i+1]),
            .step_quo (quo_s[i+1]),
            .step_dvs (dvs_s[i+1])
        );
    end

    // A zero divisor forces both numeric fields to zero.
    always_comb
    begin
        result_next.div_by_zero   = ctl_s[WIDTH].dz;
        result_next.quotient_out  = ctl_s[WIDTH].dz ? '0 : quo_cut;
        result_next.remainder_out = ctl_s[WIDTH].dz ? '0 : rem_cut;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_s[WIDTH].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The strobe is sampled at the edge that ends its cycle.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(WIDTH+2) done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, WIDTH+2))
        else $error("result strobe without a matching accepted word");

    a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.div_by_zero) |->
            (result.quotient_out == '0 && result.remainder_out == '0))
        else $error("divide-by-zero result carries nonzero fields");

    a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_s[WIDTH].valid && !ctl_s[WIDTH].dz) |-> (rem_s[WIDTH] < dvs_s[WIDTH]))
        else $error("final remainder not below the divisor");

endmodule

[verif/restoring_unsigned_divider_unit_tb.sv]
// Self-checking testbench for restoring_unsigned_divider_unit: directed corner words,
// then random words under several sender idle patterns, each result checked against
// a restoring-division predictor in a small scoreboard. Depends on rud_pkg and the RTL.
module restoring_unsigned_divider_unit_tb;

    import rud_pkg::*;

    localparam int WIDTH = FIELD_W;
    localparam int RANDOM_WORDS = 2000;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = WIDTH + 8;

    class div_scoreboard;
        result_t pending_results[$];
        int      failures;

        function new();
            failures = 0;
        endfunction

        // One shift-subtract-restore step per quotient bit; the partial remainder
        // carries one extra bit so divisors with the top bit set divide correctly.
        function result_t divide_restoring(operands_t w);
            result_t          res;
            logic [FIELD_W:0] part_rem;
            logic [FIELD_W-1:0] quo;
            res = '0;
            if (w.divisor_in == '0) begin
                res.div_by_zero = 1'b1;
                return res;
            end
            part_rem = '0;
            quo = w.dividend_in;
            for (int i = 0; i < FIELD_W; i++) begin
                part_rem = {part_rem[FIELD_W-1:0], quo[FIELD_W-1]};
                quo = quo << 1;
                if (part_rem >= {1'b0, w.divisor_in}) begin
                    part_rem = part_rem - {1'b0, w.divisor_in};
                    quo[0] = 1'b1;
                end
            end
            res.quotient_out = quo;
            res.remainder_out = part_rem[FIELD_W-1:0];
            return res;
        endfunction

        function void note_word(operands_t w);
            pending_results.push_back(divide_restoring(w));
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: q=%h r=%h dz=%b", $time,
                         got.quotient_out, got.remainder_out, got.div_by_zero);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.quotient_out !== want.quotient_out) begin
                $display("%0t: quotient_out expected %h actual %h", $time,
                         want.quotient_out, got.quotient_out);
                failures++;
            end
            if (got.remainder_out !== want.remainder_out) begin
                $display("%0t: remainder_out expected %h actual %h", $time,
                         want.remainder_out, got.remainder_out);
                failures++;
            end
            if (got.div_by_zero !== want.div_by_zero) begin
                $display("%0t: div_by_zero expected %b actual %b", $time,
                         want.div_by_zero, got.div_by_zero);
                failures++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    operands_t operands;
    logic      done;
    result_t   result;

    div_scoreboard board;
    int        quiet_cycles;

    restoring_unsigned_divider_unit #(.WIDTH(WIDTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Inputs change only by nonblocking assignment, so these are pre-edge values.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) board.note_word(operands);
            if (done) board.check_word(result);
            if ((start && !busy) || done) begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic operands_t random_operands();
        operands_t w;
        w.dividend_in = $urandom;
        w.divisor_in = $urandom;
        case ($urandom_range(9))
            0: w.divisor_in = '0;
            1: w.divisor_in = $urandom_range(1, 15);
            2: w.divisor_in[FIELD_W-1] = 1'b1;
            3: w.dividend_in = w.dividend_in >> $urandom_range(FIELD_W - 1);
            4: w.divisor_in = w.dividend_in;
            5: w.divisor_in = 32'h1 << $urandom_range(FIELD_W - 1);
            6: w.divisor_in = w.divisor_in >> $urandom_range(FIELD_W - 1);
            7: w.dividend_in = w.divisor_in - $urandom_range(1);
            default: ;
        endcase
        return w;
    endfunction

    // Holds start high until the word is taken at an edge with busy low.
    task automatic send_word(input operands_t w);
        start <= 1'b1;
        operands <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Idles the sender for a run of cycles, with junk on the operand bus.
    task automatic sender_gap(input int idle_pct);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                operands <= random_operands();
                @(posedge clk);
            end
        end
    endtask

    initial begin
        operands_t directed[$];
        int        idle_pct;
        directed = '{
            '{32'h0000_0000, 32'h0000_0001}, '{32'h0000_0000, 32'h0000_0000},
            '{32'hffff_ffff, 32'h0000_0000}, '{32'h0000_0001, 32'h0000_0000},
            '{32'hffff_ffff, 32'h0000_0001}, '{32'hffff_ffff, 32'hffff_ffff},
            '{32'h0000_0001, 32'hffff_ffff}, '{32'hffff_fffe, 32'hffff_ffff},
            '{32'hffff_ffff, 32'hffff_fffe}, '{32'hffff_ffff, 32'h8000_0000},
            '{32'h8000_0000, 32'h8000_0000}, '{32'h7fff_ffff, 32'h8000_0000},
            '{32'h8000_0000, 32'h8000_0001}, '{32'hffff_ffff, 32'h8000_0001},
            '{32'h0000_0005, 32'h0000_0003}, '{32'h0000_0000, 32'hffff_ffff},
            '{32'hffff_ffff, 32'h0000_0002}, '{32'h8000_0000, 32'h0000_0001},
            '{32'h1234_5678, 32'h0000_0100}, '{32'h0000_0007, 32'h0000_0007},
            '{32'h0000_0006, 32'h0000_0007}
        };
        board = new();
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operands = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_word(directed[i]);

        // Phases: back to back, sender mostly idle, sender sometimes idle, mixed.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            case (n / (RANDOM_WORDS / 4))
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 32;
                default: idle_pct = ((n / 40) % 2 == 0) ? 0 : 88;
            endcase
            send_word(random_operands());
            sender_gap(idle_pct);
        end
        start <= 1'b0;

        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.pending_results.size() == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rud_pkg.sv
rtl/rud_step.sv
rtl/restoring_unsigned_divider_unit.sv
verif/restoring_unsigned_divider_unit_tb.sv
